// ----- hdl/assert_macros.svh -----
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// property must hold at every clock edge outside reset
`define ASSERT_CLK(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("assertion failed");

// expression must never be true outside reset
`define ASSERT_NEVER(label, expr) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error("assertion failed");

`else

`define ASSERT_CLK(label, prop)
`define ASSERT_NEVER(label, expr)

`endif

`endif

// ----- hdl/sfd_pkg.sv -----
package sfd_pkg;

	localparam logic [7:0] FLAG_BYTE  = 8'h7E;
	localparam logic [7:0] ESC_BYTE   = 8'h7D;
	localparam logic [7:0] ESC_XOR    = 8'h20;
	localparam logic [8:0] SUM_TARGET = 9'h0FF;

	typedef enum logic [2:0] {
		PH_IDLE    = 3'd0,
		PH_SEQ     = 3'd1,
		PH_RECID   = 3'd2,
		PH_LEN     = 3'd3,
		PH_PAYLOAD = 3'd4,
		PH_CHKSUM  = 3'd5
	} phase_t;

	typedef enum logic [2:0] {
		KIND_NONE    = 3'd0,
		KIND_BYTE    = 3'd1,
		KIND_GOOD    = 3'd2,
		KIND_BAD     = 3'd3,
		KIND_ABANDON = 3'd4
	} kind_t;

	typedef enum logic [1:0] {
		ROLE_SEQ     = 2'd0,
		ROLE_RECID   = 2'd1,
		ROLE_LEN     = 2'd2,
		ROLE_PAYLOAD = 2'd3
	} role_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] data;
		role_t      role;
		logic       last;
	} result_t;

endpackage

// ----- hdl/sfd_parser.sv -----
module sfd_parser (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  logic [7:0]       line_byte,
	output sfd_pkg::result_t result
);
	import sfd_pkg::*;

	phase_t     phase_q, phase_d;
	logic       esc_q, esc_d;
	logic [7:0] remaining_q, remaining_d;
	logic [7:0] sum_q, sum_d;
	logic [7:0] val;
	logic [7:0] rem_dec;
	logic [8:0] sum9;
	kind_t      kind;
	logic [7:0] data;
	role_t      role;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			esc_q       <= 1'b0;
			remaining_q <= 8'd0;
			sum_q       <= 8'd0;
		end else if (step) begin
			phase_q     <= phase_d;
			esc_q       <= esc_d;
			remaining_q <= remaining_d;
			sum_q       <= sum_d;
		end
	end

	always_comb begin
		val         = esc_q ? (line_byte ^ ESC_XOR) : line_byte;
		sum9        = {1'b0, sum_q} + {1'b0, val};
		rem_dec     = remaining_q - 8'd1;
		phase_d     = phase_q;
		esc_d       = esc_q;
		remaining_d = remaining_q;
		sum_d       = sum_q;
		kind        = KIND_NONE;
		data        = 8'd0;
		role        = ROLE_SEQ;

		if (!(phase_q inside {PH_SEQ, PH_RECID, PH_LEN, PH_PAYLOAD, PH_CHKSUM})) begin
			// hunting: only a flag matters
			if (line_byte == FLAG_BYTE) begin
				phase_d = PH_SEQ;
				esc_d   = 1'b0;
				sum_d   = 8'd0;
			end else begin
				phase_d = PH_IDLE;
			end
		end else if (line_byte == FLAG_BYTE) begin
			// restart; abandon only if something was already emitted
			phase_d = PH_SEQ;
			esc_d   = 1'b0;
			sum_d   = 8'd0;
			if (phase_q != PH_SEQ) begin
				kind = KIND_ABANDON;
			end
		end else if (line_byte == ESC_BYTE) begin
			if (esc_q) begin
				esc_d   = 1'b0;
				phase_d = PH_IDLE;
				kind    = KIND_ABANDON;
			end else begin
				esc_d = 1'b1;
			end
		end else begin
			esc_d = 1'b0;
			if (phase_q == PH_CHKSUM) begin
				phase_d = PH_SEQ;
				sum_d   = 8'd0;
				kind    = (sum9 == SUM_TARGET) ? KIND_GOOD : KIND_BAD;
			end else begin
				sum_d = sum9[7:0];
				kind  = KIND_BYTE;
				data  = val;
				case (phase_q)
					PH_SEQ: begin
						phase_d = PH_RECID;
						role    = ROLE_SEQ;
					end
					PH_RECID: begin
						phase_d = PH_LEN;
						role    = ROLE_RECID;
					end
					PH_LEN: begin
						remaining_d = val;
						phase_d     = (val == 8'd0) ? PH_CHKSUM : PH_PAYLOAD;
						role        = ROLE_LEN;
					end
					default: begin
						remaining_d = rem_dec;
						if (rem_dec == 8'd0) begin
							phase_d = PH_CHKSUM;
						end
						role = ROLE_PAYLOAD;
					end
				endcase
			end
		end

		result.kind = kind;
		result.data = data;
		result.role = role;
		result.last = (kind == KIND_GOOD) || (kind == KIND_BAD) || (kind == KIND_ABANDON);
	end

endmodule

// ----- hdl/stuffed_frame_deframer.sv -----
// Byte-stuffed frame receiver. Every accepted line byte gives exactly one result item, in
// order: either nothing, an unescaped field byte tagged with its role, or a frame-end
// mark (good, checksum bad, abandoned) with last_of_frame set. An item passes an input
// register and then the parser and lands in the result register; a held result keeps it
// waiting in the input register. One byte is taken every cycle while result_stall is low.
// The parser state (phase, escape, payload count, sum) updates once per item.
`include "assert_macros.svh"

module stuffed_frame_deframer (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       line_valid,
	output logic       line_stall,
	input  logic [7:0] line_byte,
	output logic       result_valid,
	input  logic       result_stall,
	output logic [2:0] result_kind,
	output logic [7:0] field_byte,
	output logic [1:0] byte_role,
	output logic       last_of_frame
);
	import sfd_pkg::*;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       out_valid_q;
	result_t    out_q;
	result_t    step_result;
	logic       out_hold;
	logic       advance;
	logic       accept;
	logic       end_kind;
	logic       fields_clear;

	assign out_hold   = out_valid_q && result_stall;
	assign advance    = valid_s1 && !out_hold;
	assign line_stall = valid_s1 && out_hold;
	assign accept     = line_valid && !line_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= line_byte;
		end
		if (advance) begin
			out_q <= step_result;
		end
	end

	sfd_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.line_byte (byte_s1),
		.result    (step_result)
	);

	assign result_valid  = out_valid_q;
	assign result_kind   = out_q.kind;
	assign field_byte    = out_q.data;
	assign byte_role     = out_q.role;
	assign last_of_frame = out_q.last;

	assign end_kind     = (result_kind == KIND_GOOD) || (result_kind == KIND_BAD) ||
		(result_kind == KIND_ABANDON);
	assign fields_clear = (field_byte == 8'd0) && (byte_role == ROLE_SEQ);

	// the input side only backs up when both stages are full and the output is held
	`ASSERT_CLK(a_stall_only_when_full, line_stall |-> (valid_s1 && out_valid_q))
	// frame-end marks and the last flag agree
	`ASSERT_CLK(a_last_matches_kind, result_valid |-> (last_of_frame == end_kind))
	// only field byte items carry data or a role
	`ASSERT_CLK(a_quiet_fields, (result_valid && (result_kind != KIND_BYTE)) |-> fields_clear)
	// a stage that moves on always leaves the output register filled
	`ASSERT_CLK(a_advance_fills_output, advance |=> result_valid)

endmodule
